### hdl/hrd_pkg.sv
// Shared types, codes and constants for the HTTP response end detector.
// Used by hrd_hdr_scan and http_response_end_detector; no dependencies.
package hrd_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int LEN_W          = 32;
    localparam int BYTE_W         = 8;
    localparam int OP_W           = 2;
    localparam int KEY_LEN        = 15;
    localparam int NEEDLE_W       = 5;
    localparam int BLANK_W        = 3;

    localparam logic [LEN_W-1:0] MAX_BYTES_RESET = 32'd65536;

    // operation codes
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // end reasons
    localparam logic [1:0] END_RUNNING = 2'd0;
    localparam logic [1:0] END_LENGTH  = 2'd1;
    localparam logic [1:0] END_CLOSED  = 2'd2;
    localparam logic [1:0] END_FULL    = 2'd3;

    // length modes
    localparam logic [1:0] MODE_UNKNOWN = 2'd0;
    localparam logic [1:0] MODE_LENGTH  = 2'd1;
    localparam logic [1:0] MODE_EOF     = 2'd2;

    // blank line progress once CR LF CR LF has been seen
    localparam logic [BLANK_W-1:0] BLANK_DONE = 3'd4;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

    // lower-case "content-length:"
    function automatic logic [BYTE_W-1:0] key_char(input logic [3:0] idx);
        logic [BYTE_W-1:0] c;
        unique case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // header scanner status towards the top level (values after this beat)
    typedef struct packed {
        logic             active;      // headers still in progress before this beat
        logic             complete;    // blank line seen after this beat
        logic             len_ok;      // usable Content-Length after this beat
        logic [LEN_W-1:0] length_cur;  // parsed value before this beat
        logic [LEN_W-1:0] length_next; // parsed value after this beat
    } hdr_scan_t;

endpackage

### hdl/hrd_hdr_scan.sv
// Header scanner: blank line detection and Content-Length line parsing.
// Depends on hrd_pkg.
module hrd_hdr_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          step,
    input  logic [hrd_pkg::BYTE_W-1:0]    data_byte,
    output hrd_pkg::hdr_scan_t            status
);

    typedef enum logic [2:0] {
        PH_KEY      = 3'd0,
        PH_WAIT_CR  = 3'd1,
        PH_SKIP_WS  = 3'd2,
        PH_DIGITS   = 3'd3,
        PH_WAIT_LF  = 3'd4,
        PH_FOUND    = 3'd5,
        PH_STOP     = 3'd6
    } phase_t;

    localparam int LW = hrd_pkg::LEN_W;

    phase_t                          phase_reg, phase_next;
    logic [hrd_pkg::NEEDLE_W-1:0]    needle_reg, needle_next;
    logic                            neg_reg, neg_next;
    logic [LW-1:0]                   len_reg, len_next;
    logic [hrd_pkg::BLANK_W-1:0]     blank_reg, blank_next;

    logic [hrd_pkg::BYTE_W-1:0]      lc;
    logic                            is_digit, is_cr, is_lf, is_ws, is_sign;
    logic [LW+3:0]                   acc;
    logic [LW-1:0]                   acc_sat;
    phase_t                          line_end_phase;

    assign is_cr   = (data_byte == hrd_pkg::CH_CR);
    assign is_lf   = (data_byte == hrd_pkg::CH_LF);
    assign is_ws   = (data_byte == hrd_pkg::CH_SPACE) || (data_byte == hrd_pkg::CH_TAB);
    assign is_sign = (data_byte == hrd_pkg::CH_PLUS) || (data_byte == hrd_pkg::CH_MINUS);
    assign is_digit = (data_byte >= hrd_pkg::CH_ZERO) && (data_byte <= hrd_pkg::CH_NINE);
    assign lc = ((data_byte >= hrd_pkg::CH_UP_A) && (data_byte <= hrd_pkg::CH_UP_Z))
              ? data_byte + hrd_pkg::CASE_OFS : data_byte;

    // value * 10 + digit, saturating at the 32-bit maximum
    assign acc = {len_reg, 3'b000} + {2'b00, len_reg, 1'b0}
               + (LW+4)'(data_byte - hrd_pkg::CH_ZERO);
    assign acc_sat = (|acc[LW+3:LW]) ? '1 : acc[LW-1:0];

    assign line_end_phase = is_cr ? PH_WAIT_LF : PH_WAIT_CR;

    always_comb
    begin
        phase_next  = phase_reg;
        needle_next = needle_reg;
        neg_next    = neg_reg;
        len_next    = len_reg;
        blank_next  = blank_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_KEY:
                begin
                    if ((needle_reg < hrd_pkg::NEEDLE_W'(hrd_pkg::KEY_LEN)) &&
                        (lc == hrd_pkg::key_char(needle_reg[3:0])))
                    begin
                        needle_next = needle_reg + 1'b1;
                        if (needle_next == hrd_pkg::NEEDLE_W'(hrd_pkg::KEY_LEN))
                        begin
                            phase_next = PH_SKIP_WS;
                        end
                    end
                    else
                    begin
                        needle_next = '0;
                        phase_next  = line_end_phase;
                    end
                end
                PH_WAIT_CR:
                begin
                    if (is_cr)
                    begin
                        phase_next = PH_WAIT_LF;
                    end
                end
                PH_SKIP_WS:
                begin
                    priority if (is_ws)
                    begin
                        phase_next = PH_SKIP_WS;
                    end
                    else if (is_sign)
                    begin
                        neg_next   = (data_byte == hrd_pkg::CH_MINUS);
                        phase_next = PH_DIGITS;
                    end
                    else if (is_digit)
                    begin
                        len_next   = acc_sat;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = line_end_phase;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        len_next = acc_sat;
                    end
                    else
                    begin
                        phase_next = line_end_phase;
                    end
                end
                PH_WAIT_LF:
                begin
                    priority if (!is_lf)
                    begin
                        phase_next = PH_STOP;
                    end
                    else if (needle_reg == hrd_pkg::NEEDLE_W'(hrd_pkg::KEY_LEN))
                    begin
                        phase_next = PH_FOUND;
                    end
                    else
                    begin
                        phase_next  = PH_KEY;
                        needle_next = '0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            unique case (blank_reg)
                3'd1:    blank_next = is_lf ? 3'd2 : (is_cr ? 3'd1 : 3'd0);
                3'd2:    blank_next = is_cr ? 3'd3 : 3'd0;
                3'd3:    blank_next = is_lf ? hrd_pkg::BLANK_DONE : (is_cr ? 3'd1 : 3'd0);
                default: blank_next = is_cr ? 3'd1 : 3'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_KEY;
            needle_reg <= '0;
            neg_reg    <= 1'b0;
            len_reg    <= '0;
            blank_reg  <= '0;
        end
        else if (clear)
        begin
            phase_reg  <= PH_KEY;
            needle_reg <= '0;
            neg_reg    <= 1'b0;
            len_reg    <= '0;
            blank_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            needle_reg <= needle_next;
            neg_reg    <= neg_next;
            len_reg    <= len_next;
            blank_reg  <= blank_next;
        end
    end

    assign status.active      = (blank_reg != hrd_pkg::BLANK_DONE);
    assign status.complete    = (blank_next == hrd_pkg::BLANK_DONE);
    assign status.len_ok      = (phase_next == PH_FOUND) && !(neg_reg && (len_reg != '0));
    assign status.length_cur  = len_reg;
    assign status.length_next = len_next;

endmodule

### hdl/http_response_end_detector.sv
// HTTP response end detector: one beat in, one status beat out per item.
// Path: input beat to result beat through the input register, then the result register.
// Throughput: one item per cycle unless m_tready stalls it; set by the counter update.
// Reset (rst_n, asynchronous): buffer capacity 65536, response cleared, both sides empty.
// Depends on hrd_pkg and hrd_hdr_scan.
module http_response_end_detector #(
    parameter int COUNT_BITS = hrd_pkg::COUNT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration: max_response_bytes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hrd_pkg::LEN_W-1:0]    cfg_data,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hrd_pkg::BYTE_W-1:0]   s_tdata,  // [7:0] data_byte
    input  logic [hrd_pkg::OP_W-1:0]     s_tuser,  // [1:0] operation
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [71:0]                  m_tdata   // [0] store_byte, [1] done_res,
                                                   // [3:2] end_reason, [4] headers_complete,
                                                   // [6:5] length_mode,
                                                   // [38:7] body_length,
                                                   // [70:39] byte_count
);

    localparam int LW    = hrd_pkg::LEN_W;
    localparam int CMP_W = (COUNT_BITS > LW) ? COUNT_BITS : LW;
    localparam int SUM_W = CMP_W + 1;

    logic                          in_valid_reg;
    logic [hrd_pkg::OP_W-1:0]      in_op_reg;
    logic [hrd_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                          advance;

    logic [LW-1:0]                 max_bytes_reg;
    logic [COUNT_BITS-1:0]         total_reg, total_next;
    logic [COUNT_BITS-1:0]         expected_reg, expected_next;
    logic [1:0]                    mode_reg, mode_next;
    logic [1:0]                    reason_reg, reason_next;

    logic                          out_valid_reg;
    logic                          store_reg, store_next;
    logic                          hc_reg, hc_next;
    logic [LW-1:0]                 clen_reg, clen_next;

    hrd_pkg::hdr_scan_t            scan;
    logic                          scan_step, scan_clear;

    logic [COUNT_BITS-1:0]         total_inc;
    logic [CMP_W-1:0]              cfg_ext;
    logic                          full_now, full_after;
    logic [SUM_W-1:0]              exp_sum;
    logic                          exp_sat;
    logic [COUNT_BITS-1:0]         exp_val;
    logic                          completing, len_hit;
    logic [CMP_W-1:0]              total_ext;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= hrd_pkg::MAX_BYTES_RESET;
        end
        else if (cfg_valid)
        begin
            max_bytes_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    hrd_hdr_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (scan_clear),
        .step      (scan_step),
        .data_byte (in_byte_reg),
        .status    (scan)
    );

    assign total_inc = total_reg + 1'b1;
    assign total_ext = CMP_W'(total_reg);
    assign cfg_ext   = CMP_W'(max_bytes_reg);
    assign full_now   = (total_ext >= cfg_ext) || (&total_reg);
    assign full_after = (CMP_W'(total_inc) >= cfg_ext) || (&total_inc);

    // kept count plus body length, saturating at the counter maximum
    assign exp_sum = SUM_W'(total_ext) + SUM_W'(scan.length_cur) + SUM_W'(1);
    assign exp_sat = |exp_sum[CMP_W:COUNT_BITS];
    assign exp_val = exp_sat ? '1 : exp_sum[COUNT_BITS-1:0];

    assign scan_clear = advance && (in_op_reg == hrd_pkg::OP_CLEAR);
    assign scan_step  = advance && (in_op_reg == hrd_pkg::OP_BYTE) &&
                        (reason_reg == hrd_pkg::END_RUNNING) && !full_now && scan.active;
    assign completing = scan_step && scan.complete;

    always_comb
    begin
        priority if (completing && scan.len_ok)
        begin
            len_hit = exp_sat ? (&total_inc) : (scan.length_cur == '0);
        end
        else
        begin
            len_hit = (total_inc >= expected_reg);
        end
    end

    always_comb
    begin
        total_next    = total_reg;
        expected_next = expected_reg;
        mode_next     = mode_reg;
        reason_next   = reason_reg;
        store_next    = 1'b0;
        hc_next       = !scan.active;
        clen_next     = scan.length_cur;
        unique case (in_op_reg)
            hrd_pkg::OP_CLEAR:
            begin
                total_next    = '0;
                expected_next = '0;
                mode_next     = hrd_pkg::MODE_UNKNOWN;
                reason_next   = hrd_pkg::END_RUNNING;
                hc_next       = 1'b0;
            end
            hrd_pkg::OP_CLOSE:
            begin
                if (reason_reg == hrd_pkg::END_RUNNING)
                begin
                    reason_next = hrd_pkg::END_CLOSED;
                end
            end
            hrd_pkg::OP_BYTE:
            begin
                if (reason_reg == hrd_pkg::END_RUNNING)
                begin
                    if (full_now)
                    begin
                        reason_next = hrd_pkg::END_FULL;
                    end
                    else
                    begin
                        store_next = 1'b1;
                        total_next = total_inc;
                        hc_next    = !scan.active || scan.complete;
                        clen_next  = scan.length_next;
                        if (completing)
                        begin
                            mode_next = scan.len_ok ? hrd_pkg::MODE_LENGTH
                                                    : hrd_pkg::MODE_EOF;
                            if (scan.len_ok)
                            begin
                                expected_next = exp_val;
                            end
                        end
                        priority if ((mode_next == hrd_pkg::MODE_LENGTH) && len_hit)
                        begin
                            reason_next = hrd_pkg::END_LENGTH;
                        end
                        else if (full_after)
                        begin
                            reason_next = hrd_pkg::END_FULL;
                        end
                        else
                        begin
                            reason_next = hrd_pkg::END_RUNNING;
                        end
                    end
                end
            end
            default:
            begin
                reason_next = reason_reg;
            end
        endcase
        if (mode_next != hrd_pkg::MODE_LENGTH)
        begin
            clen_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            expected_reg  <= '0;
            mode_reg      <= hrd_pkg::MODE_UNKNOWN;
            reason_reg    <= hrd_pkg::END_RUNNING;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                total_reg    <= total_next;
                expected_reg <= expected_next;
                mode_reg     <= mode_next;
                reason_reg   <= reason_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            store_reg <= store_next;
            hc_reg    <= hc_next;
            clen_reg  <= clen_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, total_ext[LW-1:0], clen_reg, mode_reg, hc_reg,
                       reason_reg, (reason_reg != hrd_pkg::END_RUNNING), store_reg};

    // the result register being empty always frees the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // an end reason holds until the next clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (reason_reg != hrd_pkg::END_RUNNING) &&
        !(advance && (in_op_reg == hrd_pkg::OP_CLEAR))
        |=> (reason_reg == $past(reason_reg)))
        else $error("end reason changed without clear");

    // the kept count moves only when an item is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(total_reg))
        else $error("byte count changed without an item");

    // a known length always leaves a nonzero end point
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == hrd_pkg::MODE_LENGTH) |-> (expected_reg != '0))
        else $error("length mode with zero end point");

endmodule
